>>> rtl/ssec_pkg.sv
// Types, codes and helper functions for the stereo sonar echo capture block.
package ssec_pkg;

    localparam int TIME_W  = 16;
    localparam int COUNT_W = 4;
    localparam int CH_W    = 2;
    localparam int ACT_W   = 3;
    localparam int OP_W    = 3;
    localparam int CFG_W   = 3;
    localparam int DIR_W   = 17;

    localparam logic [OP_W-1:0] OP_RIGHT_EDGE = 3'd0;
    localparam logic [OP_W-1:0] OP_LEFT_EDGE  = 3'd1;
    localparam logic [OP_W-1:0] OP_WIN_END    = 3'd2;
    localparam logic [OP_W-1:0] OP_START      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_SPARE_LO   = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI   = 3'd7;

    localparam logic [CFG_W-1:0] REG_BLANK_TIME    = 3'd0;
    localparam logic [CFG_W-1:0] REG_BURST_WINDOW  = 3'd1;
    localparam logic [CFG_W-1:0] REG_PULSES_NEEDED = 3'd2;
    localparam logic [CFG_W-1:0] REG_DIFF_LIMIT    = 3'd3;
    localparam logic [CFG_W-1:0] REG_FREE_RUNNING  = 3'd4;

    localparam logic [TIME_W-1:0]  RST_BLANK_TIME    = 16'd1000;
    localparam logic [TIME_W-1:0]  RST_BURST_WINDOW  = 16'd30;
    localparam logic [COUNT_W-1:0] RST_PULSES_NEEDED = 4'd3;
    localparam logic [TIME_W-1:0]  RST_DIFF_LIMIT    = 16'd100;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  start;
        logic [COUNT_W-1:0] count;
    } t_side;

    typedef struct packed {
        logic [TIME_W-1:0]       fused;
        logic signed [DIR_W-1:0] dir;
    } t_fusion;

    function automatic t_side side_edge(
        input t_side              side,
        input logic [TIME_W-1:0]  t,
        input logic               measuring,
        input logic [TIME_W-1:0]  blank_time,
        input logic [TIME_W-1:0]  burst_window,
        input logic [COUNT_W-1:0] pulses_needed
    );
        t_side                   nxt;
        logic signed [TIME_W:0]  diff;
        nxt  = side;
        diff = $signed({1'b0, t}) - $signed({1'b0, side.start});
        if (measuring && (t >= blank_time) && (side.count < pulses_needed)) begin
            if (diff < $signed({1'b0, burst_window})) begin
                nxt.count = side.count + 4'd1;
            end else begin
                nxt.start = t;
                nxt.count = 4'd1;
            end
            if (nxt.count >= pulses_needed) begin
                nxt.start = t;
            end
        end
        return nxt;
    endfunction

    function automatic t_fusion fuse(
        input logic [TIME_W-1:0] r,
        input logic [TIME_W-1:0] l,
        input logic [TIME_W-1:0] limit
    );
        t_fusion                 res;
        logic signed [DIR_W-1:0] dt;
        logic [TIME_W-1:0]       mag;
        logic [TIME_W:0]         sum;
        dt  = $signed({1'b0, r}) - $signed({1'b0, l});
        mag = dt[DIR_W-1] ? TIME_W'(-dt) : dt[TIME_W-1:0];
        sum = {1'b0, r} + {1'b0, l};
        if (mag < limit) begin
            res.fused = sum[TIME_W:1];
            res.dir   = dt;
        end else begin
            res.fused = (l < r) ? l : r;
            res.dir   = '0;
        end
        return res;
    endfunction

endpackage

>>> rtl/stereo_sonar_echo_capture.sv
// Top level of the stereo sonar echo capture block.
//
// Input channel (i_in_valid / o_in_ready) carries one event word: a right or
// left comparator edge with its timer count, a window end, a channel start
// or a channel read. Output channel (o_out_valid / i_out_ready) carries one
// result word for each window end taken while measuring and for each read.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user writes it only while the block is idle, which the block does not enforce.
// Each event is handled in the cycle it is accepted; its result word sits in
// the output register from the next cycle, and one event is taken every
// cycle while the receiver keeps up.
// When the output register is full and the receiver stalls, o_in_ready falls
// until the word is taken; a word taken frees the register in the same cycle.
// Reset clears the channel state, the stored ranges and the output valid
// flag, but not the result fields, and loads the configuration defaults.
module stereo_sonar_echo_capture #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ssec_pkg::CFG_W-1:0]            i_cfg_idx,
    input  logic [ssec_pkg::TIME_W-1:0]           i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ssec_pkg::OP_W-1:0]             i_opcode,
    input  logic [ssec_pkg::TIME_W-1:0]           i_edge_time,
    input  logic [ssec_pkg::CH_W-1:0]             i_channel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_kind,
    output logic [ssec_pkg::CH_W-1:0]             o_result_channel,
    output logic [ssec_pkg::TIME_W-1:0]           o_right_range,
    output logic [ssec_pkg::TIME_W-1:0]           o_left_range,
    output logic [ssec_pkg::TIME_W-1:0]           o_fused_range,
    output logic signed [ssec_pkg::DIR_W-1:0]     o_direction
);

    localparam int STORE_DEPTH = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
    localparam logic [ssec_pkg::ACT_W-1:0] LAST_CH = ssec_pkg::ACT_W'(NUM_CHANNELS - 1);
    localparam logic [ssec_pkg::ACT_W:0]   NUM_CH  = (ssec_pkg::ACT_W + 1)'(NUM_CHANNELS);

    logic [ssec_pkg::TIME_W-1:0]  r_blank_time;
    logic [ssec_pkg::TIME_W-1:0]  r_burst_window;
    logic [ssec_pkg::COUNT_W-1:0] r_pulses_needed;
    logic [ssec_pkg::TIME_W-1:0]  r_diff_limit;
    logic                         r_free_running;

    logic [ssec_pkg::ACT_W-1:0]   r_active, n_active;
    logic                         r_measuring, n_measuring;
    ssec_pkg::t_side              r_right, n_right;
    ssec_pkg::t_side              r_left, n_left;
    logic [2*ssec_pkg::TIME_W-1:0] r_store [STORE_DEPTH];

    logic                          r_out_valid;
    logic                          r_kind, n_kind;
    logic [ssec_pkg::CH_W-1:0]     r_res_ch, n_res_ch;
    logic [ssec_pkg::TIME_W-1:0]   r_right_rng, n_right_rng;
    logic [ssec_pkg::TIME_W-1:0]   r_left_rng, n_left_rng;
    logic [ssec_pkg::TIME_W-1:0]   r_fused, n_fused;
    logic signed [ssec_pkg::DIR_W-1:0] r_dir, n_dir;

    logic                          accept;
    logic                          n_emit;
    logic                          store_we;
    logic [2*ssec_pkg::TIME_W-1:0] store_rd;
    logic                          read_ok;
    logic [ssec_pkg::TIME_W-1:0]   win_r, win_l, sel_r, sel_l;
    ssec_pkg::t_fusion             fz;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign read_ok    = {1'b0, i_channel} < NUM_CH[ssec_pkg::ACT_W-1:0]
                        || NUM_CHANNELS > 4;

    always_comb begin
        store_rd = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i_channel == ssec_pkg::CH_W'(i)) begin
                store_rd = r_store[i];
            end
        end
    end

    assign win_r = (r_right.count >= r_pulses_needed) ? r_right.start : '0;
    assign win_l = (r_left.count >= r_pulses_needed) ? r_left.start : '0;

    always_comb begin
        if (i_opcode == ssec_pkg::OP_READ) begin
            sel_r = read_ok ? store_rd[ssec_pkg::TIME_W-1:0] : '0;
            sel_l = read_ok ? store_rd[2*ssec_pkg::TIME_W-1:ssec_pkg::TIME_W] : '0;
        end else begin
            sel_r = win_r;
            sel_l = win_l;
        end
    end

    assign fz = ssec_pkg::fuse(sel_r, sel_l, r_diff_limit);

    always_comb begin
        n_active    = r_active;
        n_measuring = r_measuring;
        n_right     = r_right;
        n_left      = r_left;
        n_emit      = 1'b0;
        store_we    = 1'b0;
        n_kind      = ssec_pkg::KIND_MEASURE;
        n_res_ch    = r_active[ssec_pkg::CH_W-1:0];
        case (i_opcode)
            ssec_pkg::OP_RIGHT_EDGE: begin
                n_right = ssec_pkg::side_edge(r_right, i_edge_time, r_measuring,
                                              r_blank_time, r_burst_window,
                                              r_pulses_needed);
            end
            ssec_pkg::OP_LEFT_EDGE: begin
                n_left = ssec_pkg::side_edge(r_left, i_edge_time, r_measuring,
                                             r_blank_time, r_burst_window,
                                             r_pulses_needed);
            end
            ssec_pkg::OP_WIN_END: begin
                if (r_measuring) begin
                    n_emit   = 1'b1;
                    store_we = 1'b1;
                    if (r_free_running) begin
                        n_active = (r_active >= LAST_CH) ? '0 : r_active + 1'b1;
                        n_right  = '0;
                        n_left   = '0;
                    end else begin
                        n_measuring = 1'b0;
                    end
                end
            end
            ssec_pkg::OP_START: begin
                if ({1'b0, i_channel} < NUM_CH[ssec_pkg::ACT_W-1:0] || NUM_CHANNELS > 4) begin
                    n_active    = ssec_pkg::ACT_W'(i_channel);
                    n_measuring = 1'b1;
                    n_right     = '0;
                    n_left      = '0;
                end
            end
            ssec_pkg::OP_READ: begin
                n_emit   = 1'b1;
                n_kind   = ssec_pkg::KIND_READ;
                n_res_ch = i_channel;
            end
            default: begin
            end
        endcase
        n_right_rng = sel_r;
        n_left_rng  = sel_l;
        n_fused     = fz.fused;
        n_dir       = fz.dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_time    <= ssec_pkg::RST_BLANK_TIME;
            r_burst_window  <= ssec_pkg::RST_BURST_WINDOW;
            r_pulses_needed <= ssec_pkg::RST_PULSES_NEEDED;
            r_diff_limit    <= ssec_pkg::RST_DIFF_LIMIT;
            r_free_running  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssec_pkg::REG_BLANK_TIME:    r_blank_time    <= i_cfg_wdata;
                ssec_pkg::REG_BURST_WINDOW:  r_burst_window  <= i_cfg_wdata;
                ssec_pkg::REG_PULSES_NEEDED:
                    r_pulses_needed <= i_cfg_wdata[ssec_pkg::COUNT_W-1:0];
                ssec_pkg::REG_DIFF_LIMIT:    r_diff_limit    <= i_cfg_wdata;
                ssec_pkg::REG_FREE_RUNNING:  r_free_running  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_measuring <= 1'b0;
            r_right     <= '0;
            r_left      <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (accept) begin
            r_active    <= n_active;
            r_measuring <= n_measuring;
            r_right     <= n_right;
            r_left      <= n_left;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (store_we && r_active == ssec_pkg::ACT_W'(i)) begin
                    r_store[i] <= {win_l, win_r};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind      <= n_kind;
            r_res_ch    <= n_res_ch;
            r_right_rng <= n_right_rng;
            r_left_rng  <= n_left_rng;
            r_fused     <= n_fused;
            r_dir       <= n_dir;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_result_channel = r_res_ch;
    assign o_right_range    = r_right_rng;
    assign o_left_range     = r_left_rng;
    assign o_fused_range    = r_fused;
    assign o_direction      = r_dir;

endmodule

>>> tb/stereo_sonar_echo_capture_checker.sv
// Checker for the stereo sonar echo capture block: predicts each result word and compares.
`timescale 1ns / 100ps
module stereo_sonar_echo_capture_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ssec_pkg::CFG_W-1:0]        i_cfg_idx,
    input  logic [ssec_pkg::TIME_W-1:0]       i_cfg_wdata,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [ssec_pkg::OP_W-1:0]         i_opcode,
    input  logic [ssec_pkg::TIME_W-1:0]       i_edge_time,
    input  logic [ssec_pkg::CH_W-1:0]         i_channel,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_kind,
    input  logic [ssec_pkg::CH_W-1:0]         i_result_channel,
    input  logic [ssec_pkg::TIME_W-1:0]       i_right_range,
    input  logic [ssec_pkg::TIME_W-1:0]       i_left_range,
    input  logic [ssec_pkg::TIME_W-1:0]       i_fused_range,
    input  logic signed [ssec_pkg::DIR_W-1:0] i_direction,
    output int                                o_mismatches,
    output int                                o_reports_due
);

    typedef struct {
        logic                              kind;
        logic [ssec_pkg::CH_W-1:0]         chan;
        logic [ssec_pkg::TIME_W-1:0]       right;
        logic [ssec_pkg::TIME_W-1:0]       left;
        logic [ssec_pkg::TIME_W-1:0]       fused;
        logic signed [ssec_pkg::DIR_W-1:0] dir;
    } t_range_report;

    logic [ssec_pkg::TIME_W-1:0]   blank_time    = ssec_pkg::RST_BLANK_TIME;
    logic [ssec_pkg::TIME_W-1:0]   burst_window  = ssec_pkg::RST_BURST_WINDOW;
    logic [ssec_pkg::COUNT_W-1:0]  pulses_needed = ssec_pkg::RST_PULSES_NEEDED;
    logic [ssec_pkg::TIME_W-1:0]   diff_limit    = ssec_pkg::RST_DIFF_LIMIT;
    logic                          free_running  = 1'b0;

    logic [ssec_pkg::ACT_W-1:0]    active_ch = '0;
    logic                          measuring = 1'b0;
    logic [ssec_pkg::TIME_W-1:0]   side_start [2] = '{default: '0};
    logic [ssec_pkg::COUNT_W-1:0]  side_count [2] = '{default: '0};
    logic [2*ssec_pkg::TIME_W-1:0] range_mem [NUM_CHANNELS] = '{default: '0};

    t_range_report                 reports_due [$];
    int                            mismatches = 0;

    function automatic void clear_sides();
        side_start = '{default: '0};
        side_count = '{default: '0};
    endfunction

    // side 0 is right, side 1 is left
    function automatic void apply_edge(int side, logic [ssec_pkg::TIME_W-1:0] t);
        int gap;
        if (!measuring || t < blank_time || side_count[side] >= pulses_needed)
            return;
        gap = int'(t) - int'(side_start[side]);
        if (gap < int'(burst_window)) begin
            side_count[side] = side_count[side] + 1'b1;
        end else begin
            side_start[side] = t;
            side_count[side] = ssec_pkg::COUNT_W'(1);
        end
        if (side_count[side] >= pulses_needed)
            side_start[side] = t;
    endfunction

    function automatic t_range_report make_report(logic kind,
                                                  logic [ssec_pkg::CH_W-1:0] ch,
                                                  logic [ssec_pkg::TIME_W-1:0] r,
                                                  logic [ssec_pkg::TIME_W-1:0] l);
        t_range_report rep;
        int            delta;
        int            spread;
        delta     = int'(r) - int'(l);
        spread    = (delta < 0) ? -delta : delta;
        rep.kind  = kind;
        rep.chan  = ch;
        rep.right = r;
        rep.left  = l;
        if (spread < int'(diff_limit)) begin
            rep.fused = ssec_pkg::TIME_W'((int'(r) + int'(l)) >> 1);
            rep.dir   = ssec_pkg::DIR_W'(delta);
        end else begin
            rep.fused = (l < r) ? l : r;
            rep.dir   = '0;
        end
        return rep;
    endfunction

    function automatic void take_word(logic [ssec_pkg::OP_W-1:0] op,
                                      logic [ssec_pkg::TIME_W-1:0] t,
                                      logic [ssec_pkg::CH_W-1:0] ch);
        logic [ssec_pkg::TIME_W-1:0] r;
        logic [ssec_pkg::TIME_W-1:0] l;
        r = '0;
        l = '0;
        case (op)
            ssec_pkg::OP_RIGHT_EDGE: apply_edge(0, t);
            ssec_pkg::OP_LEFT_EDGE:  apply_edge(1, t);
            ssec_pkg::OP_WIN_END: begin
                if (measuring) begin
                    if (side_count[0] >= pulses_needed)
                        r = side_start[0];
                    if (side_count[1] >= pulses_needed)
                        l = side_start[1];
                    range_mem[active_ch] = {l, r};
                    reports_due.push_back(make_report(ssec_pkg::KIND_MEASURE,
                                                      ssec_pkg::CH_W'(active_ch), r, l));
                    if (free_running) begin
                        if (int'(active_ch) + 1 >= NUM_CHANNELS)
                            active_ch = '0;
                        else
                            active_ch = active_ch + 1'b1;
                        clear_sides();
                    end else begin
                        measuring = 1'b0;
                    end
                end
            end
            ssec_pkg::OP_START: begin
                if (ch < NUM_CHANNELS) begin
                    active_ch = ch;
                    measuring = 1'b1;
                    clear_sides();
                end
            end
            ssec_pkg::OP_READ: begin
                if (ch < NUM_CHANNELS)
                    {l, r} = range_mem[ch];
                reports_due.push_back(make_report(ssec_pkg::KIND_READ, ch, r, l));
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_range_report want;
        if (!i_rst_n) begin
            blank_time    = ssec_pkg::RST_BLANK_TIME;
            burst_window  = ssec_pkg::RST_BURST_WINDOW;
            pulses_needed = ssec_pkg::RST_PULSES_NEEDED;
            diff_limit    = ssec_pkg::RST_DIFF_LIMIT;
            free_running  = 1'b0;
            active_ch     = '0;
            measuring     = 1'b0;
            clear_sides();
            range_mem     = '{default: '0};
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssec_pkg::REG_BLANK_TIME:    blank_time    = i_cfg_wdata;
                    ssec_pkg::REG_BURST_WINDOW:  burst_window  = i_cfg_wdata;
                    ssec_pkg::REG_PULSES_NEEDED:
                        pulses_needed = i_cfg_wdata[ssec_pkg::COUNT_W-1:0];
                    ssec_pkg::REG_DIFF_LIMIT:    diff_limit    = i_cfg_wdata;
                    ssec_pkg::REG_FREE_RUNNING:  free_running  = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected word: expected nothing, got channel %0d",
                             $time, i_result_channel);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("result_channel", 32'(want.chan), 32'(i_result_channel));
                    check_field("right_range", 32'(want.right), 32'(i_right_range));
                    check_field("left_range", 32'(want.left), 32'(i_left_range));
                    check_field("fused_range", 32'(want.fused), 32'(i_fused_range));
                    check_field("direction", 32'(want.dir), 32'(i_direction));
                end
            end
            if (i_in_valid && i_in_ready)
                take_word(i_opcode, i_edge_time, i_channel);
        end
        o_mismatches  <= mismatches;
        o_reports_due <= reports_due.size();
    end

endmodule

>>> tb/stereo_sonar_echo_capture_tb.sv
// Testbench top for the stereo sonar echo capture block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module stereo_sonar_echo_capture_tb;

    localparam int NUM_CH        = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_OFF      = 400;
    localparam int HOLD_AT       = 120;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [ssec_pkg::CFG_W-1:0]        cfg_idx   = '0;
    logic [ssec_pkg::TIME_W-1:0]       cfg_wdata = '0;
    logic                              in_valid  = 1'b0;
    logic [ssec_pkg::OP_W-1:0]         opcode    = '0;
    logic [ssec_pkg::TIME_W-1:0]       edge_time = '0;
    logic [ssec_pkg::CH_W-1:0]         channel   = '0;
    logic                              out_ready = 1'b0;

    logic                              in_ready;
    logic                              out_valid;
    logic                              kind;
    logic [ssec_pkg::CH_W-1:0]         result_channel;
    logic [ssec_pkg::TIME_W-1:0]       right_range;
    logic [ssec_pkg::TIME_W-1:0]       left_range;
    logic [ssec_pkg::TIME_W-1:0]       fused_range;
    logic signed [ssec_pkg::DIR_W-1:0] direction;

    int mismatches;
    int reports_due;
    int n_accepted   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int tx_gap_pct;
    int rx_gap_pct;
    int sent         = 0;

    int cur_blank  = ssec_pkg::RST_BLANK_TIME;
    int cur_window = ssec_pkg::RST_BURST_WINDOW;
    int cur_needed = ssec_pkg::RST_PULSES_NEEDED;
    int cur_limit  = ssec_pkg::RST_DIFF_LIMIT;
    int cur_free   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stereo_sonar_echo_capture #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_edge_time      (edge_time),
        .i_channel        (channel),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (kind),
        .o_result_channel (result_channel),
        .o_right_range    (right_range),
        .o_left_range     (left_range),
        .o_fused_range    (fused_range),
        .o_direction      (direction)
    );

    stereo_sonar_echo_capture_checker #(
        .NUM_CHANNELS(NUM_CH)
    ) echo_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_edge_time      (edge_time),
        .i_channel        (channel),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_kind           (kind),
        .i_result_channel (result_channel),
        .i_right_range    (right_range),
        .i_left_range     (left_range),
        .i_fused_range    (fused_range),
        .i_direction      (direction),
        .o_mismatches     (mismatches),
        .o_reports_due    (reports_due)
    );

    assign tx_gap_pct = (n_accepted < 330) ? 8 : (n_accepted < 660) ? 52 : 0;
    assign rx_gap_pct = (n_accepted < 330) ? 52 : (n_accepted < 660) ? 8 : 0;

    always @(posedge clk) begin
        if (!rst_n)
            n_accepted <= 0;
        else if (in_valid && in_ready)
            n_accepted <= n_accepted + 1;
    end

    // hold off once for a long stretch so the block fills and stalls its input
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_OFF;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_gap_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(logic [ssec_pkg::OP_W-1:0] op, int t, int ch);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        edge_time <= ssec_pkg::TIME_W'(t);
        channel   <= ssec_pkg::CH_W'(ch);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ssec_pkg::CFG_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= ssec_pkg::TIME_W'(value);
        @(posedge clk);
    endtask

    task automatic set_config(int blank, int window, int needed, int limit, int free_run);
        settle();
        cur_blank  = blank;
        cur_window = window;
        cur_needed = needed;
        cur_limit  = limit;
        cur_free   = free_run;
        write_reg(ssec_pkg::REG_BLANK_TIME, blank);
        write_reg(ssec_pkg::REG_BURST_WINDOW, window);
        write_reg(ssec_pkg::REG_PULSES_NEEDED, needed);
        write_reg(ssec_pkg::REG_DIFF_LIMIT, limit);
        write_reg(ssec_pkg::REG_FREE_RUNNING, free_run);
        cfg_we <= 1'b0;
    endtask

    task automatic run_measurement();
        int span;
        int base_r;
        int base_l;
        int n_edges;
        int side;
        int t;
        span = (cur_window > 3000) ? 3000 : cur_window;
        if (cur_free == 0 || $urandom_range(0, 9) != 0)
            send_word(ssec_pkg::OP_START, $urandom_range(0, 65535), $urandom_range(0, 3));
        base_r = cur_blank + $urandom_range(0, 4000);
        if ($urandom_range(0, 9) == 0)
            base_r = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) != 0)
            base_l = base_r + $urandom_range(0, 2 * cur_limit + 2) - (cur_limit + 1);
        else
            base_l = cur_blank + $urandom_range(0, 4000);
        n_edges = $urandom_range(0, 2 * cur_needed + 4);
        for (int k = 0; k < n_edges; k++) begin
            side = $urandom_range(0, 1);
            t    = side ? base_l : base_r;
            case ($urandom_range(0, 9))
                0:       t = $urandom_range(0, cur_blank);
                1:       t = t + span + $urandom_range(0, 200);
                2:       t = t - $urandom_range(0, span);
                default: t = t + $urandom_range(0, span - 1);
            endcase
            send_word(side ? ssec_pkg::OP_LEFT_EDGE : ssec_pkg::OP_RIGHT_EDGE, t,
                      $urandom_range(0, 3));
        end
        send_word(ssec_pkg::OP_WIN_END, $urandom_range(0, 65535), $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            send_word(ssec_pkg::OP_READ, $urandom_range(0, 65535), $urandom_range(0, 3));
    endtask

    task automatic run_random(int count);
        int goal;
        goal = sent + count;
        while (sent < goal) begin
            if ($urandom_range(0, 99) < 20)
                send_word(ssec_pkg::OP_W'($urandom_range(0, 7)), $urandom_range(0, 65535),
                          $urandom_range(0, 3));
            else
                run_measurement();
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(ssec_pkg::OP_READ, 0, 0);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 1500, 0);
        send_word(ssec_pkg::OP_WIN_END, 0, 0);
        send_word(ssec_pkg::OP_START, 0, 1);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 0, 0);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 1000, 0);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 1010, 0);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 1029, 0);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 2000, 0);
        send_word(ssec_pkg::OP_LEFT_EDGE, 1200, 0);
        send_word(ssec_pkg::OP_LEFT_EDGE, 1300, 0);
        send_word(ssec_pkg::OP_LEFT_EDGE, 1290, 0);
        send_word(ssec_pkg::OP_LEFT_EDGE, 1310, 0);
        send_word(ssec_pkg::OP_WIN_END, 0, 0);
        send_word(ssec_pkg::OP_START, 0, 2);
        send_word(ssec_pkg::OP_START, 0, 3);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 65535, 3);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 65535, 3);
        send_word(ssec_pkg::OP_RIGHT_EDGE, 65535, 3);
        send_word(ssec_pkg::OP_LEFT_EDGE, 65500, 3);
        send_word(ssec_pkg::OP_LEFT_EDGE, 65510, 3);
        send_word(ssec_pkg::OP_LEFT_EDGE, 65520, 3);
        send_word(ssec_pkg::OP_WIN_END, 65535, 3);
        send_word(ssec_pkg::OP_READ, 0, 3);
        send_word(ssec_pkg::OP_READ, 65535, 1);
        send_word(ssec_pkg::OP_SPARE_HI, 0, 0);
        send_word(ssec_pkg::OP_SPARE_LO, 65535, 3);

        set_config(300, 20, 3, 150, 0);
        run_random(150);
        set_config(0, 1, 1, 0, 1);
        run_random(150);
        set_config(65535, 65535, 15, 65535, 0);
        run_random(100);
        set_config(500, 40, 0, 200, 1);
        run_random(60);
        set_config($urandom_range(0, 2000), $urandom_range(5, 300), $urandom_range(1, 8),
                   $urandom_range(0, 600), $urandom_range(0, 1));
        run_random(220);
        set_config($urandom_range(0, 2000), $urandom_range(5, 300), $urandom_range(1, 8),
                   $urandom_range(0, 600), 1 - cur_free);
        run_random(220);

        settle();
        if (mismatches == 0 && reports_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
